>>> hdl/escpwm_pkg.sv
// ----------------------------------------------------------------------------
// ESC PWM package
// Item types, codes and constants shared by the PWM generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package escpwm_pkg;

  localparam int MAX_CHANNELS = 4;

  // Register reset values
  localparam logic [15:0] RESET_PERIOD = 16'd20972;
  localparam logic [15:0] RESET_CENTER = 16'd1573;
  localparam logic [15:0] RESET_SPAN   = 16'd420;

  // Accepted speed range
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;
  localparam logic signed [7:0] SPEED_MAX = 8'sd100;

  // Motor numbers
  localparam logic [2:0] MOTOR_NONE = 3'd0;
  localparam logic [2:0] MOTOR_ALL  = 3'd5;

  // Item command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Division by 100 as multiply by ceil(2^30/100) and shift; exact below 2^23
  localparam logic [23:0] DIV100_RECIP = 24'd10737419;
  localparam int          DIV100_SHIFT = 30;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_CENTER = 2'd1,
    REG_SPAN   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_NOCHAN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_HOLD = 2'd2
  } op_t;

  typedef struct packed {
    logic              cmd;
    logic signed [7:0] speed;
    logic [2:0]        motor;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pwm_out;
    logic [1:0] status;
  } out_item_t;

  // Classified work handed from the front to the back
  typedef struct packed {
    op_t                     op;
    status_t                 status;
    logic [MAX_CHANNELS-1:0] mask;
    logic [15:0]             value;
  } work_t;

endpackage

`default_nettype wire

>>> hdl/escpwm_fifo.sv
// ----------------------------------------------------------------------------
// ESC PWM queue
// Small first-in first-out register queue with an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module escpwm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && (count != CW'(DEPTH));
  assign do_pop  = pop && (count != '0);
  assign rdata   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/escpwm_front.sv
// ----------------------------------------------------------------------------
// ESC PWM front end
// Classify items and compute the compare value in a three-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module escpwm_front #(
  parameter int CHANNELS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire escpwm_pkg::in_item_t item,
  input  wire logic [15:0]          center_width,
  input  wire logic [15:0]          speed_span,
  output logic                      work_valid,
  output escpwm_pkg::work_t         work,
  output logic [1:0]                inflight
);

  import escpwm_pkg::*;

  localparam int QUOT_W = 17;

  // Stage 1: classification and product
  logic signed [24:0]       prod_full;
  logic [MAX_CHANNELS-1:0]  sel;
  logic [MAX_CHANNELS-1:0]  present;
  logic                     speed_ok;
  logic                     motor_ok;
  op_t                      op_in;
  status_t                  status_in;

  logic                     v1;
  op_t                      op1;
  status_t                  status1;
  logic [MAX_CHANNELS-1:0]  mask1;
  logic signed [23:0]       prod1;

  // Stage 2: magnitude divided by 100
  logic                     neg1;
  logic [23:0]              mag_full;
  logic [46:0]              quot_full;

  logic                     v2;
  op_t                      op2;
  status_t                  status2;
  logic [MAX_CHANNELS-1:0]  mask2;
  logic                     neg2;
  logic [QUOT_W-1:0]        quot2;

  // Stage 3: add center and saturate
  logic signed [18:0]       sum;
  logic [15:0]              value;

  assign prod_full = item.speed * $signed({1'b0, speed_span});
  assign speed_ok  = item.speed inside {[SPEED_MIN:SPEED_MAX]};
  assign motor_ok  = item.motor inside {[MOTOR_NONE:MOTOR_ALL]};

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      present[c] = (c < CHANNELS);
      sel[c]     = (item.motor == MOTOR_ALL) || (item.motor == 3'(MAX_CHANNELS - c));
    end
    if (item.cmd == CMD_TICK) begin
      op_in     = OP_TICK;
      status_in = STATUS_OK;
    end else if (speed_ok && motor_ok) begin
      op_in     = OP_SET;
      status_in = ((sel & present) == '0) ? STATUS_NOCHAN : STATUS_OK;
    end else begin
      op_in     = OP_HOLD;
      status_in = STATUS_REJECT;
    end
  end

  assign neg1      = prod1[23];
  assign mag_full  = neg1 ? 24'(-prod1) : prod1;
  assign quot_full = mag_full[22:0] * DIV100_RECIP;

  assign sum = neg2 ? $signed({3'b000, center_width}) - $signed({2'b00, quot2})
                    : $signed({3'b000, center_width}) + $signed({2'b00, quot2});

  always_comb begin
    if (sum < 0) begin
      value = 16'h0000;
    end else if (sum > $signed(19'h0ffff)) begin
      value = 16'hffff;
    end else begin
      value = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      work_valid <= 1'b0;
    end else begin
      v1         <= accept;
      v2         <= v1;
      work_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    op1     <= op_in;
    status1 <= status_in;
    mask1   <= sel & present;
    prod1   <= $signed(prod_full[23:0]);

    op2     <= op1;
    status2 <= status1;
    mask2   <= mask1;
    neg2    <= neg1;
    quot2   <= quot_full[DIV100_SHIFT +: QUOT_W];

    work.op     <= op2;
    work.status <= status2;
    work.mask   <= mask2;
    work.value  <= value;
  end

  assign inflight = {1'b0, v1} + {1'b0, v2} + {1'b0, work_valid};

endmodule

`default_nettype wire

>>> hdl/escpwm_back.sv
// ----------------------------------------------------------------------------
// ESC PWM back end
// Hold the tick counter and channel compares, apply work, form results.
// ----------------------------------------------------------------------------
`default_nettype none

module escpwm_back #(
  parameter int CHANNELS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [15:0]       period_top,
  input  wire logic              work_valid,
  input  wire escpwm_pkg::work_t work,
  input  wire logic              out_room,
  output logic                   take,
  output escpwm_pkg::out_item_t  res
);

  import escpwm_pkg::*;

  logic [15:0]             tick_count;
  logic [15:0]             tick_count_next;
  logic                    apply;
  logic [MAX_CHANNELS-1:0] pwm;

  assign take  = work_valid && out_room;
  assign apply = take && (work.op == OP_SET);

  always_comb begin
    tick_count_next = tick_count;
    if (take) begin
      case (work.op)
        OP_TICK: tick_count_next = (tick_count >= period_top) ? 16'h0000
                                                              : tick_count + 16'h0001;
        OP_SET:  tick_count_next = 16'h0000;
        default: tick_count_next = tick_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 16'h0000;
    end else begin
      tick_count <= tick_count_next;
    end
  end

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_ch
    if (c < CHANNELS) begin : g_on
      logic [15:0] compare;
      logic [15:0] compare_next;

      assign compare_next = (apply && work.mask[c]) ? work.value : compare;
      assign pwm[c]       = tick_count_next < compare_next;

      always_ff @(posedge clk) begin
        if (rst) begin
          compare <= RESET_CENTER;
        end else begin
          compare <= compare_next;
        end
      end
    end else begin : g_off
      assign pwm[c] = 1'b0;
    end
  end

  assign res.pwm_out = pwm;
  assign res.status  = work.status;

endmodule

`default_nettype wire

>>> hdl/four_channel_esc_pwm_core.sv
// ----------------------------------------------------------------------------
// Four-channel ESC PWM core
// Shared up-counter with per-channel compare values driven by set-speed items.
// ----------------------------------------------------------------------------
// The block takes one item per clock while not full and returns one result per
// item, in order. A tick item advances the shared counter (it wraps to zero once
// it has reached period_top); a set-speed item with speed in -100..100 and motor
// 0..5 computes trunc(speed*speed_span/100)+center_width, saturated to
// 0..65535, writes it to the chosen channel (motors 1..4 drive channels 3..0,
// motor 5 all present channels, motor 0 none) and clears the counter. Every
// result carries the channel levels after the item has taken effect (bit c
// high while the counter is below compare c) and a status: 0 tick or applied,
// 1 rejected, 2 accepted without a channel. Throughput is one item per cycle
// while full is low; a result reaches the output ports through five register
// stages, the first loading at the edge that accepts its item: the three-stage
// front pipeline (product, divide by 100 through a reciprocal multiply, center
// add and saturate), one in the work queue and one in the result queue. The
// front end stops taking items (full) when the work queue plus the items in
// its pipeline reach MID_DEPTH, which only happens while results back up
// because pop stays low. Configuration registers are always ready and must be
// written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_esc_pwm_core #(
  parameter int CHANNELS  = 4,
  parameter int MID_DEPTH = 8,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // item side
  input  wire logic                  push,
  output logic                       full,
  input  wire escpwm_pkg::in_item_t  item,
  // result side
  output logic                       empty,
  input  wire logic                  pop,
  output escpwm_pkg::out_item_t      result,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  import escpwm_pkg::*;

  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int WW  = $bits(work_t);
  localparam int RW  = $bits(out_item_t);

  logic [15:0]    period_top;
  logic [15:0]    center_width;
  logic [15:0]    speed_span;

  logic           accept;
  logic           front_valid;
  work_t          front_work;
  logic [1:0]     inflight;

  logic [WW-1:0]  mid_rdata;
  logic [MCW-1:0] mid_count;
  work_t          mid_work;

  logic           take;
  out_item_t      back_res;
  logic           out_room;
  logic [RW-1:0]  out_rdata;
  logic [OCW-1:0] out_count;

  // Configuration registers: always ready, ignore unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_top   <= RESET_PERIOD;
      center_width <= RESET_CENTER;
      speed_span   <= RESET_SPAN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD: period_top   <= cfg_data;
        REG_CENTER: center_width <= cfg_data;
        REG_SPAN:   speed_span   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Hold off new items while the work queue could overflow with what is in flight
  assign full   = ((MCW + 2)'(mid_count) + (MCW + 2)'(inflight)) >= (MCW + 2)'(MID_DEPTH);
  assign accept = push && !full;

  escpwm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .center_width (center_width),
    .speed_span   (speed_span),
    .work_valid   (front_valid),
    .work         (front_work),
    .inflight     (inflight)
  );

  escpwm_fifo #(
    .WIDTH (WW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_work),
    .pop   (take),
    .rdata (mid_rdata),
    .count (mid_count)
  );

  assign mid_work = work_t'(mid_rdata);
  assign out_room = out_count != OCW'(OUT_DEPTH);

  escpwm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .period_top (period_top),
    .work_valid (mid_count != '0),
    .work       (mid_work),
    .out_room   (out_room),
    .take       (take),
    .res        (back_res)
  );

  // Result queue parts the back end from the consumer
  escpwm_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (back_res),
    .pop   (pop && !empty),
    .rdata (out_rdata),
    .count (out_count)
  );

  assign empty  = out_count == '0;
  assign result = out_item_t'(out_rdata);

endmodule

`default_nettype wire

>>> test/four_channel_esc_pwm_core_test.sv
// ----------------------------------------------------------------------------
// Four-channel ESC PWM core testbench
// Drives tick and set-speed items through the item port and compares every
// result against a cycle-free model of the counter and compare registers,
// across several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_esc_pwm_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import escpwm_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 94;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {ROW_ITEM, ROW_REGS} row_kind_t;

  // One line of the directed table: either an item (with an optional
  // hand-written result) or a new setting of all three registers.
  typedef struct {
    row_kind_t   kind;
    in_item_t    stim;
    bit          typed;
    out_item_t   want;
    logic [15:0] period;
    logic [15:0] center;
    logic [15:0] span;
  } table_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    item;
  logic        empty;
  logic        pop;
  out_item_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Model of the block: registers, shared counter and compare values
  logic [15:0] model_period;
  logic [15:0] model_center;
  logic [15:0] model_span;
  logic [15:0] model_count;
  logic [15:0] model_compare [MAX_CHANNELS];

  out_item_t   pending_results [$];
  table_row_t  directed_rows [$];

  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  four_channel_esc_pwm_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one item to the model and return the levels and status it yields.
  function automatic out_item_t predict_pwm_result(in_item_t stim);
    out_item_t  res;
    int         spd;
    int         level;
    logic [15:0] cmp;
    res.status = STATUS_OK;
    spd = $signed(stim.speed);
    if (stim.cmd == CMD_TICK) begin
      // a count at or above the period wraps, even when the period shrank
      if (model_count >= model_period) begin
        model_count = '0;
      end else begin
        model_count = model_count + 16'd1;
      end
    end else if (spd >= SPEED_MIN && spd <= SPEED_MAX && stim.motor <= MOTOR_ALL) begin
      // integer division truncates toward zero, as the block does
      level = (spd * int'(model_span)) / 100 + int'(model_center);
      if (level < 0) begin
        cmp = '0;
      end else if (level > 65535) begin
        cmp = 16'hFFFF;
      end else begin
        cmp = level[15:0];
      end
      model_count = '0;
      if (stim.motor == MOTOR_ALL) begin
        for (int c = 0; c < MAX_CHANNELS; c++) model_compare[c] = cmp;
      end else if (stim.motor == MOTOR_NONE) begin
        res.status = STATUS_NOCHAN;
      end else begin
        // motors 1..4 drive channels 3..0
        model_compare[MAX_CHANNELS - int'(stim.motor)] = cmp;
      end
    end else begin
      res.status = STATUS_REJECT;
    end
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      res.pwm_out[c] = (model_count < model_compare[c]);
    end
    return res;
  endfunction

  function automatic void add_item(logic cmd, int spd, int motor, bit typed = 1'b0,
                                   logic [3:0] pwm = '0, status_t st = STATUS_OK);
    table_row_t row;
    row = '{kind: ROW_ITEM, default: '0};
    row.kind       = ROW_ITEM;
    row.stim.cmd   = cmd;
    row.stim.speed = spd[7:0];
    row.stim.motor = motor[2:0];
    row.typed      = typed;
    row.want.pwm_out = pwm;
    row.want.status  = st;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_regs(int period, int center, int span);
    table_row_t row;
    row = '{kind: ROW_REGS, default: '0};
    row.kind   = ROW_REGS;
    row.period = period[15:0];
    row.center = center[15:0];
    row.span   = span[15:0];
    directed_rows.push_back(row);
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // Offer one item, idling first at the current rate, and hold it until the
  // block takes it. Returns just after the accepting edge.
  task automatic send_item(in_item_t stim, bit typed = 1'b0, out_item_t want = '0);
    out_item_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= stim;
    do @(posedge clk); while (full);
    // the model always advances; a typed row replaces only the expectation
    predicted = predict_pwm_result(stim);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drain the block, then write all three registers back to back.
  task automatic write_registers(logic [15:0] period, logic [15:0] center,
                                 logic [15:0] span);
    logic [15:0] vals [3];
    cfg_reg_t    idx  [3];
    vals = '{period, center, span};
    idx  = '{REG_PERIOD, REG_CENTER, REG_SPAN};
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_PERIOD: model_period = vals[i];
        REG_CENTER: model_center = vals[i];
        default:    model_span   = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each popped item against the oldest expectation, then
  // pick the pop level for the next edge.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: pwm_out %h status %0d",
                               result.pwm_out, result.status));
        end else begin
          want = pending_results.pop_front();
          if (result.pwm_out !== want.pwm_out) begin
            flag_error($sformatf("pwm_out expected %h got %h",
                                 want.pwm_out, result.pwm_out));
          end
          if (result.status !== want.status) begin
            flag_error($sformatf("status expected %0d got %0d",
                                 want.status, result.status));
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Bound the run in case the block stops moving.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int        send_pct [4];
    int        recv_pct [4];
    int        r;
    in_item_t  stim;
    // idle patterns: none, sender only, receiver only, both
    send_pct = '{0, 54, 0, 25};
    recv_pct = '{0, 0, 54, 25};

    rst       = 1'b1;
    push      = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    model_period = RESET_PERIOD;
    model_center = RESET_CENTER;
    model_span   = RESET_SPAN;
    model_count  = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) model_compare[c] = RESET_CENTER;

    // Directed part. At reset every compare is 1573 and the count is near
    // zero, so all four outputs stay high until the compares are driven to 0.
    add_item(CMD_TICK,  0,    0, 1, 4'hF, STATUS_OK);
    add_item(CMD_SET,   100,  1, 1, 4'hF, STATUS_OK);
    add_item(CMD_SET,   -100, 2, 1, 4'hF, STATUS_OK);
    add_item(CMD_SET,   0,    3, 1, 4'hF, STATUS_OK);
    // out-of-range speeds and motors are rejected
    add_item(CMD_SET,   127,  4, 1, 4'hF, STATUS_REJECT);
    add_item(CMD_SET,   -128, 5, 1, 4'hF, STATUS_REJECT);
    add_item(CMD_SET,   101,  1, 1, 4'hF, STATUS_REJECT);
    add_item(CMD_SET,   -101, 4, 1, 4'hF, STATUS_REJECT);
    add_item(CMD_SET,   50,   6, 1, 4'hF, STATUS_REJECT);
    add_item(CMD_SET,   -50,  7, 1, 4'hF, STATUS_REJECT);
    // motor 0 only clears the counter
    add_item(CMD_SET,   10,   0, 1, 4'hF, STATUS_NOCHAN);
    add_item(CMD_SET,   -1,   5);
    // tick ignores the speed and motor fields
    add_item(CMD_TICK,  -128, 7);
    add_item(CMD_TICK,  127,  0);
    // saturation at the top, short period wrap
    add_regs(2, 65535, 65535);
    add_item(CMD_SET,   100,  5, 1, 4'hF, STATUS_OK);
    add_item(CMD_TICK,  0,    0);
    add_item(CMD_TICK,  0,    0);
    add_item(CMD_TICK,  0,    0);
    // saturation at zero drops the channel low
    add_regs(2, 0, 65535);
    add_item(CMD_SET,   -100, 1, 1, 4'h7, STATUS_OK);
    add_item(CMD_SET,   -1,   4);
    add_item(CMD_TICK,  0,    0);
    // zero period holds the count at zero
    add_regs(0, 3, 0);
    add_item(CMD_SET,   5,    5);
    add_item(CMD_TICK,  0,    0);
    add_item(CMD_TICK,  0,    0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REGS) begin
        write_registers(directed_rows[i].period, directed_rows[i].center,
                        directed_rows[i].span);
      end else begin
        send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part: each phase takes a new register setting and idle pattern.
    // Small periods and compares keep the count crossing the compares often.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       write_registers(16'hFFFF, 16'h0000, 16'hFFFF);
        1:       write_registers(16'h0001, 16'hFFFF, 16'h0000);
        7:       write_registers(RESET_PERIOD, RESET_CENTER, RESET_SPAN);
        default: write_registers(16'($urandom_range(1, 120)), 16'($urandom_range(0, 100)),
                                 16'($urandom_range(0, 200)));
      endcase
      send_idle_pct  = send_pct[ph % 4];
      recv_stall_pct = recv_pct[ph % 4];
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        stim.speed = 8'($urandom_range(0, 255));
        stim.motor = 3'($urandom_range(0, 7));
        if (r < 55) begin
          stim.cmd = CMD_TICK;
        end else if (r < 90) begin
          // well-formed set-speed item
          stim.cmd   = CMD_SET;
          stim.speed = 8'($urandom_range(0, 200) - 100);
          stim.motor = 3'($urandom_range(0, 5));
        end else begin
          // noise: any speed and motor, rejected when out of range
          stim.cmd = CMD_SET;
        end
        send_item(stim);
      end
    end

    // Drain, then let the pipeline settle before the verdict.
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
